// File: rtl/cec_pkg.sv
// Package for the cluster extent cache.
// Holds shared constants, operation codes and the sequencer state types.
// No dependencies.
package cec_pkg;

  localparam int DATA_W            = 32;
  localparam int OP_W              = 2;
  localparam int PADDR_W           = 2;
  localparam int CACHE_ENTRIES_DEF = 16;
  localparam int CNT_W_DEF         = $clog2(CACHE_ENTRIES_DEF + 1);

  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [PADDR_W-1:0] ADDR_START_CLUS = 2'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MREAD,
    ST_MCHK,
    ST_UPD,
    ST_INSW,
    ST_RESP
  } state_t;

  // rank rewrite modes of the update pass
  typedef enum logic [1:0] {
    UPD_FRONT,
    UPD_FREE,
    UPD_FULL
  } upd_mode_t;

endpackage

// File: rtl/cec_in_if.sv
// Request channel of the cluster extent cache: valid/ready plus request payload.
// Depends on cec_pkg.
interface cec_in_if;
  logic                        valid;
  logic                        ready;
  logic [cec_pkg::OP_W-1:0]    op;
  logic [cec_pkg::DATA_W-1:0]  file_clus;
  logic [cec_pkg::DATA_W-1:0]  disk_cluster_in;

  modport source (output valid, op, file_clus, disk_cluster_in, input ready);
  modport sink   (input valid, op, file_clus, disk_cluster_in, output ready);
endinterface

// File: rtl/cec_out_if.sv
// Result channel of the cluster extent cache: valid/ready plus result payload.
// Depends on cec_pkg.
interface cec_out_if #(
  parameter int CNT_W = cec_pkg::CNT_W_DEF
);
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic [cec_pkg::DATA_W-1:0]  result_disk_cluster;
  logic [cec_pkg::DATA_W-1:0]  walk_start;
  logic [CNT_W-1:0]            entries_used;

  modport source (output valid, hit, result_disk_cluster, walk_start, entries_used,
                  input ready);
  modport sink   (input valid, hit, result_disk_cluster, walk_start, entries_used,
                  output ready);
endinterface

// File: rtl/cec_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module cec_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                    wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                    rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/cluster_extent_cache.sv
// Cluster extent cache top level: sequencer, scan logic, APB register, output stage.
// Depends on cec_pkg, cec_in_if, cec_out_if and cec_ram.
//
// Recency-ordered cache of up to CACHE_ENTRIES extents, each mapping a run of
// file clusters to a run of disk clusters. All entries live in one RAM that
// is visited one slot per cycle by a single compare/update datapath. A lookup
// miss scans the valid entries; a lookup hit scans them, then runs a pass
// that reorders the recency ranks; an insert runs a rank pass over the
// entries and/or writes the new entry; a lookup of cluster 0, a clear or an
// unused op code goes straight to the result. One transaction is in flight
// at a time, and the next request is taken as soon as the result has moved
// to the output register. No reset sweep: entries are only read below the valid count.
// The start cluster register sits at APB address 0 and resets to 0.
module cluster_extent_cache #(
  parameter int CACHE_ENTRIES = cec_pkg::CACHE_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  cec_in_if.sink                        in_ch,
  cec_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cec_pkg::PADDR_W-1:0]   paddr,
  input  logic [cec_pkg::DATA_W-1:0]    pwdata,
  output logic [cec_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  localparam int DW = cec_pkg::DATA_W;
  localparam int IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int CW = $clog2(CACHE_ENTRIES + 1);
  localparam int EW = 3 * DW + IW;
  localparam logic [CW-1:0] FULL_CNT = CW'(CACHE_ENTRIES);

  // control state
  cec_pkg::state_t    state_r, state_nxt;
  cec_pkg::upd_mode_t mode_r, mode_nxt;
  logic [DW-1:0]      start_clus_r;
  logic [CW-1:0]      vc_r, vc_nxt;
  logic [IW-1:0]      ns_r, ns_nxt;
  logic               nv_r, nv_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic               dv_r, dv_nxt;
  logic               out_valid_r, out_valid_nxt;

  // datapath registers
  logic [IW-1:0]      eidx_r, eidx_nxt;
  logic [DW-1:0]      fc_r, fc_nxt;
  logic [DW-1:0]      dc_r, dc_nxt;
  logic               fnd_v_r, fnd_v_nxt;
  logic [IW-1:0]      fnd_slot_r, fnd_slot_nxt;
  logic [IW-1:0]      fnd_rank_r, fnd_rank_nxt;
  logic [DW-1:0]      fnd_fs_r, fnd_fs_nxt;
  logic [DW-1:0]      fnd_ds_r, fnd_ds_nxt;
  logic               bst_v_r, bst_v_nxt;
  logic [IW-1:0]      bst_slot_r, bst_slot_nxt;
  logic [IW-1:0]      bst_rank_r, bst_rank_nxt;
  logic [DW-1:0]      bst_fs_r, bst_fs_nxt;
  logic [DW-1:0]      bst_ds_r, bst_ds_nxt;
  logic [DW-1:0]      bst_ex_r, bst_ex_nxt;
  logic [IW-1:0]      tgt_slot_r, tgt_slot_nxt;
  logic [IW-1:0]      tgt_rank_r, tgt_rank_nxt;
  logic               merge_r, merge_nxt;
  logic               res_hit_r, res_hit_nxt;
  logic [DW-1:0]      res_dc_r, res_dc_nxt;
  logic [DW-1:0]      res_walk_r, res_walk_nxt;
  logic               out_hit_r, out_hit_nxt;
  logic [DW-1:0]      out_dc_r, out_dc_nxt;
  logic [DW-1:0]      out_walk_r, out_walk_nxt;
  logic [CW-1:0]      out_used_r, out_used_nxt;

  // entry RAM
  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  logic [EW-1:0]      ram_wdata;
  logic [IW-1:0]      ram_raddr;
  logic [EW-1:0]      ram_rdata;

  logic [DW-1:0]      rd_fs, rd_ds, rd_ex;
  logic [IW-1:0]      rd_rank;
  logic               rd_covers, rd_lower, mrg_ok;
  cec_pkg::upd_mode_t ins_mode;
  cec_pkg::state_t    ins_state;
  logic               in_fire;

  cec_ram #(
    .WIDTH (EW),
    .DEPTH (CACHE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_fs   = ram_rdata[DW-1:0];
  assign rd_ds   = ram_rdata[2*DW-1:DW];
  assign rd_ex   = ram_rdata[3*DW-1:2*DW];
  assign rd_rank = ram_rdata[EW-1:3*DW];

  assign rd_covers = ({1'b0, rd_fs} <= {1'b0, fc_r}) &&
                     (({1'b0, rd_fs} + {1'b0, rd_ex}) >= {1'b0, fc_r});
  assign rd_lower  = rd_fs < fc_r;
  assign mrg_ok    = (({1'b0, rd_fs} + {1'b0, rd_ex} + 33'd1) == {1'b0, fc_r}) &&
                     (({1'b0, rd_ds} + {1'b0, rd_ex} + 33'd1) == {1'b0, dc_r});

  assign ins_mode  = (vc_r < FULL_CNT) ? cec_pkg::UPD_FREE : cec_pkg::UPD_FULL;
  assign ins_state = (vc_r == '0) ? cec_pkg::ST_INSW : cec_pkg::ST_UPD;

  assign in_ch.ready = (state_r == cec_pkg::ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign out_ch.valid               = out_valid_r;
  assign out_ch.hit                 = out_hit_r;
  assign out_ch.result_disk_cluster = out_dc_r;
  assign out_ch.walk_start          = out_walk_r;
  assign out_ch.entries_used        = out_used_r;

  assign pready = 1'b1;
  assign prdata = start_clus_r;

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    vc_nxt        = vc_r;
    ns_nxt        = ns_r;
    nv_nxt        = nv_r;
    idx_nxt       = idx_r;
    dv_nxt        = 1'b0;
    eidx_nxt      = idx_r[IW-1:0];
    fc_nxt        = fc_r;
    dc_nxt        = dc_r;
    fnd_v_nxt     = fnd_v_r;
    fnd_slot_nxt  = fnd_slot_r;
    fnd_rank_nxt  = fnd_rank_r;
    fnd_fs_nxt    = fnd_fs_r;
    fnd_ds_nxt    = fnd_ds_r;
    bst_v_nxt     = bst_v_r;
    bst_slot_nxt  = bst_slot_r;
    bst_rank_nxt  = bst_rank_r;
    bst_fs_nxt    = bst_fs_r;
    bst_ds_nxt    = bst_ds_r;
    bst_ex_nxt    = bst_ex_r;
    tgt_slot_nxt  = tgt_slot_r;
    tgt_rank_nxt  = tgt_rank_r;
    merge_nxt     = merge_r;
    res_hit_nxt   = res_hit_r;
    res_dc_nxt    = res_dc_r;
    res_walk_nxt  = res_walk_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_hit_nxt   = out_hit_r;
    out_dc_nxt    = out_dc_r;
    out_walk_nxt  = out_walk_r;
    out_used_nxt  = out_used_r;
    ram_we        = 1'b0;
    ram_waddr     = eidx_r;
    ram_wdata     = ram_rdata;
    ram_raddr     = idx_r[IW-1:0];

    // slot read issue shared by scan and update passes
    if ((state_r == cec_pkg::ST_SCAN || state_r == cec_pkg::ST_UPD) && idx_r < vc_r) begin
      dv_nxt  = 1'b1;
      idx_nxt = idx_r + 1'b1;
    end

    unique case (state_r)
      cec_pkg::ST_IDLE: begin
        if (in_fire) begin
          fc_nxt       = in_ch.file_clus;
          dc_nxt       = in_ch.disk_cluster_in;
          res_hit_nxt  = 1'b0;
          res_dc_nxt   = '0;
          res_walk_nxt = '0;
          idx_nxt      = '0;
          fnd_v_nxt    = 1'b0;
          bst_v_nxt    = 1'b0;
          merge_nxt    = 1'b0;
          state_nxt    = cec_pkg::ST_RESP;
          if (in_ch.op == cec_pkg::OP_LOOKUP) begin
            if (in_ch.file_clus == '0) begin
              res_hit_nxt = 1'b1;
              res_dc_nxt  = start_clus_r;
            end else begin
              state_nxt = cec_pkg::ST_SCAN;
            end
          end else if (in_ch.op == cec_pkg::OP_INSERT) begin
            res_dc_nxt   = in_ch.disk_cluster_in;
            res_walk_nxt = in_ch.file_clus;
            tgt_slot_nxt = ns_r;
            nv_nxt       = 1'b0;
            ns_nxt       = '0;
            if (nv_r && (CW'(ns_r) < vc_r)) begin
              state_nxt = cec_pkg::ST_MREAD;
            end else begin
              mode_nxt  = ins_mode;
              state_nxt = ins_state;
            end
          end else if (in_ch.op == cec_pkg::OP_CLEAR) begin
            vc_nxt = '0;
            nv_nxt = 1'b0;
            ns_nxt = '0;
          end
        end
      end

      cec_pkg::ST_SCAN: begin
        if (dv_r) begin
          if (rd_covers) begin
            if (!fnd_v_r || rd_rank < fnd_rank_r) begin
              fnd_v_nxt    = 1'b1;
              fnd_slot_nxt = eidx_r;
              fnd_rank_nxt = rd_rank;
              fnd_fs_nxt   = rd_fs;
              fnd_ds_nxt   = rd_ds;
            end
          end else if (rd_lower && (!bst_v_r || rd_fs > bst_fs_r ||
                                    (rd_fs == bst_fs_r && rd_rank < bst_rank_r))) begin
            bst_v_nxt    = 1'b1;
            bst_slot_nxt = eidx_r;
            bst_rank_nxt = rd_rank;
            bst_fs_nxt   = rd_fs;
            bst_ds_nxt   = rd_ds;
            bst_ex_nxt   = rd_ex;
          end
        end else if (idx_r == vc_r) begin
          if (fnd_v_r) begin
            res_hit_nxt  = 1'b1;
            res_dc_nxt   = fnd_ds_r + (fc_r - fnd_fs_r);
            res_walk_nxt = fc_r;
            tgt_slot_nxt = fnd_slot_r;
            tgt_rank_nxt = fnd_rank_r;
            mode_nxt     = cec_pkg::UPD_FRONT;
            idx_nxt      = '0;
            state_nxt    = cec_pkg::ST_UPD;
          end else if (bst_v_r) begin
            res_dc_nxt   = bst_ds_r + bst_ex_r;
            res_walk_nxt = bst_fs_r + bst_ex_r;
            ns_nxt       = bst_slot_r;
            nv_nxt       = 1'b1;
            state_nxt    = cec_pkg::ST_RESP;
          end else begin
            res_dc_nxt   = start_clus_r;
            res_walk_nxt = '0;
            ns_nxt       = '0;
            nv_nxt       = 1'b0;
            state_nxt    = cec_pkg::ST_RESP;
          end
        end
      end

      cec_pkg::ST_MREAD: begin
        ram_raddr = tgt_slot_r;
        state_nxt = cec_pkg::ST_MCHK;
      end

      cec_pkg::ST_MCHK: begin
        idx_nxt = '0;
        if (mrg_ok) begin
          tgt_rank_nxt = rd_rank;
          merge_nxt    = 1'b1;
          mode_nxt     = cec_pkg::UPD_FRONT;
          state_nxt    = cec_pkg::ST_UPD;
        end else begin
          mode_nxt  = ins_mode;
          state_nxt = ins_state;
        end
      end

      cec_pkg::ST_UPD: begin
        if (dv_r) begin
          ram_we = 1'b1;
          unique case (mode_r)
            cec_pkg::UPD_FRONT: begin
              if (eidx_r == tgt_slot_r) begin
                ram_wdata[EW-1:3*DW] = '0;
                if (merge_r && rd_ex != '1) begin
                  ram_wdata[3*DW-1:2*DW] = rd_ex + 1'b1;
                end
              end else if (rd_rank < tgt_rank_r) begin
                ram_wdata[EW-1:3*DW] = rd_rank + 1'b1;
              end
            end
            cec_pkg::UPD_FREE: begin
              ram_wdata[EW-1:3*DW] = rd_rank + 1'b1;
            end
            cec_pkg::UPD_FULL: begin
              if (CW'(rd_rank) == vc_r - 1'b1) begin
                ram_wdata = {{IW{1'b0}}, {DW{1'b0}}, dc_r, fc_r};
              end else begin
                ram_wdata[EW-1:3*DW] = rd_rank + 1'b1;
              end
            end
            default: begin
              ram_we = 1'b0;
            end
          endcase
        end else if (idx_r == vc_r) begin
          state_nxt = (mode_r == cec_pkg::UPD_FREE) ? cec_pkg::ST_INSW : cec_pkg::ST_RESP;
        end
      end

      cec_pkg::ST_INSW: begin
        ram_we    = 1'b1;
        ram_waddr = vc_r[IW-1:0];
        ram_wdata = {{IW{1'b0}}, {DW{1'b0}}, dc_r, fc_r};
        vc_nxt    = vc_r + 1'b1;
        state_nxt = cec_pkg::ST_RESP;
      end

      cec_pkg::ST_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = res_hit_r;
          out_dc_nxt    = res_dc_r;
          out_walk_nxt  = res_walk_r;
          out_used_nxt  = vc_r;
          state_nxt     = cec_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = cec_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= cec_pkg::ST_IDLE;
      mode_r       <= cec_pkg::UPD_FRONT;
      start_clus_r <= '0;
      vc_r         <= '0;
      ns_r         <= '0;
      nv_r         <= 1'b0;
      idx_r        <= '0;
      dv_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      vc_r        <= vc_nxt;
      ns_r        <= ns_nxt;
      nv_r        <= nv_nxt;
      idx_r       <= idx_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
      if (psel && penable && pwrite && pready && paddr == cec_pkg::ADDR_START_CLUS) begin
        start_clus_r <= pwdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    eidx_r     <= eidx_nxt;
    fc_r       <= fc_nxt;
    dc_r       <= dc_nxt;
    fnd_v_r    <= fnd_v_nxt;
    fnd_slot_r <= fnd_slot_nxt;
    fnd_rank_r <= fnd_rank_nxt;
    fnd_fs_r   <= fnd_fs_nxt;
    fnd_ds_r   <= fnd_ds_nxt;
    bst_v_r    <= bst_v_nxt;
    bst_slot_r <= bst_slot_nxt;
    bst_rank_r <= bst_rank_nxt;
    bst_fs_r   <= bst_fs_nxt;
    bst_ds_r   <= bst_ds_nxt;
    bst_ex_r   <= bst_ex_nxt;
    tgt_slot_r <= tgt_slot_nxt;
    tgt_rank_r <= tgt_rank_nxt;
    merge_r    <= merge_nxt;
    res_hit_r  <= res_hit_nxt;
    res_dc_r   <= res_dc_nxt;
    res_walk_r <= res_walk_nxt;
    out_hit_r  <= out_hit_nxt;
    out_dc_r   <= out_dc_nxt;
    out_walk_r <= out_walk_nxt;
    out_used_r <= out_used_nxt;
  end

endmodule
